/* sv/wpv_pkg.sv */
// ============================================================================
// Window peak voltmeter package
// Shared constants, status codes, register indexes and the configuration
// record used by the voltmeter modules.
// ============================================================================
`default_nettype none

package wpv_pkg;

    // Default sizes of the sample window and the converter word.
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int ADC_BITS_DEF     = 12;

    // Fixed field widths.
    localparam int ADC_MAX_BITS = 16;
    localparam int VOLT_W       = 21;
    localparam int WLEN_W       = 7;
    localparam int OUT_W        = 24;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 21;

    // Depth of the queue between the front and the back.
    localparam int JOB_Q_DEPTH = 2;

    // Amplitude scale 0.7071 as a ratio, and its reciprocal form.
    localparam int RMS_NUM   = 7071;
    localparam int RMS_DEN   = 10000;
    localparam int RMS_NUM_W = 13;
    localparam int RMS_SHIFT = 32;
    localparam logic [31:0] RMS_RECIP =
        32'((64'(RMS_NUM) << RMS_SHIFT) / 64'(RMS_DEN));

    // Output saturation bounds.
    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // Reading status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_ERR   = 2'd2;

    // Register indexes.
    typedef logic [CFG_ADDR_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_ADC_LOW   = 3'd0;
    localparam t_reg_idx REG_ADC_HIGH  = 3'd1;
    localparam t_reg_idx REG_VOLT_LOW  = 3'd2;
    localparam t_reg_idx REG_VOLT_HIGH = 3'd3;
    localparam t_reg_idx REG_WLEN      = 3'd4;
    localparam t_reg_idx REG_RMS_MODE  = 3'd5;

    // Register reset values.
    localparam logic [ADC_MAX_BITS-1:0] ADC_LOW_RST   = 16'd0;
    localparam logic [ADC_MAX_BITS-1:0] ADC_HIGH_RST  = 16'd4095;
    localparam logic signed [VOLT_W-1:0] VOLT_LOW_RST  = 21'sd0;
    localparam logic signed [VOLT_W-1:0] VOLT_HIGH_RST = 21'sd3300;
    localparam logic [WLEN_W-1:0] WLEN_RST = 7'd16;

    // Configuration record handed to the front and the back.
    typedef struct packed {
        logic [ADC_MAX_BITS-1:0]   adc_low;
        logic [ADC_MAX_BITS-1:0]   adc_high;
        logic signed [VOLT_W-1:0]  volt_low_mv;
        logic signed [VOLT_W-1:0]  volt_high_mv;
        logic [WLEN_W-1:0]         window_length;
        logic                      rms_mode;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/wpv_in_if.sv */
// ============================================================================
// Sample channel
// Valid/ready channel carrying one raw converter sample per request.
// ============================================================================
`default_nettype none

interface wpv_in_if import wpv_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* sv/wpv_out_if.sv */
// ============================================================================
// Reading channel
// Valid/ready channel carrying one voltmeter reading per request.
// ============================================================================
`default_nettype none

interface wpv_out_if import wpv_pkg::*; #(
    parameter int FILL_W = 7
);
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [OUT_W-1:0]  voltage_mv;
    logic [FILL_W-1:0]        fill;

    modport source (output valid, output status, output voltage_mv, output fill, input ready);
    modport sink   (input valid, input status, input voltage_mv, input fill, output ready);
endinterface

`default_nettype wire

/* sv/wpv_front.sv */
// ============================================================================
// Voltmeter front end
// Stores samples in the window ring, scans the window for its extremes and
// forms the code to be mapped (midpoint or scaled amplitude).
// ============================================================================
`default_nettype none

module wpv_front import wpv_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF,
    parameter int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_smp_valid,
    output logic                o_smp_ready,
    input  logic [ADC_BITS-1:0] i_sample,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output logic                o_job_short,
    output logic [FILL_W-1:0]   o_job_fill,
    output logic [ADC_BITS-1:0] o_job_code
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_W  = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;
    localparam int P_W    = ADC_BITS + RMS_NUM_W;
    localparam int RP_W   = ADC_BITS + RMS_SHIFT;
    localparam logic [LEN_W-1:0]  DEPTH_L   = LEN_W'(WINDOW_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_SCAN = 6'b000010,
        F_MID  = 6'b000100,
        F_MUL  = 6'b001000,
        F_FIX  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    // Control state.
    t_fstate             r_state, n_state;
    logic [FILL_W-1:0]   r_held, n_held;
    logic [ADDR_W-1:0]   r_wslot, n_wslot;
    logic [FILL_W-1:0]   r_left, n_left;
    logic                r_rd_vld, n_rd_vld;

    // Working values.
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic [ADC_BITS-1:0] r_mx, n_mx;
    logic [ADC_BITS-1:0] r_mn, n_mn;
    logic                r_short, n_short;
    logic [ADC_BITS-1:0] r_code, n_code;
    logic [ADC_BITS-1:0] r_d, n_d;
    logic [P_W-1:0]      r_p, n_p;
    logic [ADC_BITS-1:0] r_q0, n_q0;

    // Sample ring and its registered read port.
    logic [ADC_BITS-1:0] r_ring [WINDOW_DEPTH];
    logic [ADC_BITS-1:0] r_rd_data;

    logic                w_accept;
    logic                w_rd_en;
    logic [LEN_W-1:0]    w_wlen;
    logic [LEN_W-1:0]    w_len_l;
    logic [FILL_W-1:0]   w_len;
    logic [FILL_W-1:0]   w_held_acc;
    logic [ADC_BITS:0]   w_sum;
    logic [ADC_BITS-1:0] w_mid;
    logic [RP_W-1:0]     w_rp;
    logic [P_W-1:0]      w_qd;
    logic [P_W-1:0]      w_rem;

    assign o_smp_ready = (r_state == F_IDLE);
    assign w_accept    = i_smp_valid && (r_state == F_IDLE);
    assign w_rd_en     = (r_state == F_SCAN) && (r_left != '0);

    // Effective window length: zero acts as one, capped at the ring depth.
    assign w_wlen = LEN_W'(i_cfg.window_length);
    always_comb begin
        if (w_wlen == '0) begin
            w_len_l = LEN_W'(1);
        end else if (w_wlen > DEPTH_L) begin
            w_len_l = DEPTH_L;
        end else begin
            w_len_l = w_wlen;
        end
    end
    assign w_len = FILL_W'(w_len_l);

    // Held count after the new sample; a shrunk window drops the oldest.
    assign w_held_acc = ((r_held >= w_len) ? (w_len - FILL_W'(1)) : r_held) + FILL_W'(1);

    // Midpoint of the extremes.
    assign w_sum = {1'b0, r_mx} + {1'b0, r_mn};
    assign w_mid = w_sum[ADC_BITS:1];

    // Amplitude scaling: estimate by reciprocal, then one correction step.
    assign w_rp  = RP_W'(r_d) * RP_W'(RMS_RECIP);
    assign w_qd  = P_W'(r_q0) * P_W'(RMS_DEN);
    assign w_rem = r_p - w_qd;

    // Ring write on accept, one scan read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring[r_wslot] <= i_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_ring[r_rd_addr];
        end
    end

    // Next-state logic.
    always_comb begin
        n_state   = r_state;
        n_held    = r_held;
        n_wslot   = r_wslot;
        n_left    = r_left;
        n_rd_vld  = w_rd_en;
        n_rd_addr = r_rd_addr;
        n_mx      = r_mx;
        n_mn      = r_mn;
        n_short   = r_short;
        n_code    = r_code;
        n_d       = r_d;
        n_p       = r_p;
        n_q0      = r_q0;
        case (r_state)
            F_IDLE: begin
                if (i_smp_valid) begin
                    n_held    = w_held_acc;
                    n_wslot   = (r_wslot == LAST_SLOT) ? '0 : r_wslot + ADDR_W'(1);
                    n_rd_addr = (r_wslot == '0) ? LAST_SLOT : r_wslot - ADDR_W'(1);
                    n_left    = w_held_acc - FILL_W'(1);
                    n_mx      = i_sample;
                    n_mn      = i_sample;
                    n_short   = (w_held_acc < w_len);
                    if (w_held_acc < w_len) begin
                        n_state = F_PUSH;
                    end else if (w_held_acc == FILL_W'(1)) begin
                        n_state = F_MID;
                    end else begin
                        n_state = F_SCAN;
                    end
                end
            end
            F_SCAN: begin
                if (w_rd_en) begin
                    n_left    = r_left - FILL_W'(1);
                    n_rd_addr = (r_rd_addr == '0) ? LAST_SLOT : r_rd_addr - ADDR_W'(1);
                end
                if (r_rd_vld) begin
                    if (r_rd_data > r_mx) begin
                        n_mx = r_rd_data;
                    end
                    if (r_rd_data < r_mn) begin
                        n_mn = r_rd_data;
                    end
                end
                if ((r_left == '0) && !r_rd_vld) begin
                    n_state = F_MID;
                end
            end
            F_MID: begin
                n_code  = w_mid;
                n_d     = r_mx - w_mid;
                n_state = i_cfg.rms_mode ? F_MUL : F_PUSH;
            end
            F_MUL: begin
                n_p     = P_W'(r_d) * P_W'(RMS_NUM);
                n_q0    = w_rp[RMS_SHIFT +: ADC_BITS];
                n_state = F_FIX;
            end
            F_FIX: begin
                n_code  = (w_rem >= P_W'(RMS_DEN)) ? (r_q0 + ADC_BITS'(1)) : r_q0;
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_held   <= '0;
            r_wslot  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_wslot  <= n_wslot;
            r_left   <= n_left;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_mx      <= n_mx;
        r_mn      <= n_mn;
        r_short   <= n_short;
        r_code    <= n_code;
        r_d       <= n_d;
        r_p       <= n_p;
        r_q0      <= n_q0;
    end

    assign o_job_valid = (r_state == F_PUSH);
    assign o_job_short = r_short;
    assign o_job_fill  = r_held;
    assign o_job_code  = r_code;

endmodule

`default_nettype wire

/* sv/wpv_queue.sv */
// ============================================================================
// Voltmeter job queue
// Small first-in first-out buffer between the front end and the mapper.
// ============================================================================
`default_nettype none

module wpv_queue import wpv_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = JOB_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [DATA_W-1:0] i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_in_ready  = (r_cnt != FULL_CNT);
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    // Pointer and occupancy update.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in_data;
        end
    end

endmodule

`default_nettype wire

/* sv/wpv_back.sv */
// ============================================================================
// Voltmeter mapper
// Maps a code linearly onto the voltage range with a bit-serial divider,
// checks the bounds, saturates and holds the reading in an output register.
// ============================================================================
`default_nettype none

module wpv_back import wpv_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int FILL_W   = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_job_valid,
    output logic                    o_job_ready,
    input  logic                    i_job_short,
    input  logic [FILL_W-1:0]       i_job_fill,
    input  logic [ADC_BITS-1:0]     i_job_code,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_status                 o_status,
    output logic signed [OUT_W-1:0] o_voltage_mv,
    output logic [FILL_W-1:0]       o_fill
);

    localparam int ADIFF_W = ADC_BITS + 1;
    localparam int VD_W    = VOLT_W + 1;
    localparam int PA_W    = VOLT_W + ADIFF_W;
    localparam int PB_W    = ADIFF_W + VD_W;
    localparam int NUM_W   = PB_W + 1;
    localparam int DEN_W   = ADC_BITS;
    localparam int RES_W   = NUM_W + 1;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MUL  = 7'b0000010,
        B_SUM  = 7'b0000100,
        B_ABS  = 7'b0001000,
        B_DIV  = 7'b0010000,
        B_SGN  = 7'b0100000,
        B_FIN  = 7'b1000000
    } t_bstate;

    // Control state.
    t_bstate                 r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_ovalid, n_ovalid;

    // Working values.
    logic [ADC_BITS-1:0]     r_code, n_code;
    logic [FILL_W-1:0]       r_fill, n_fill;
    t_status                 r_kind, n_kind;
    logic signed [PA_W-1:0]  r_pa, n_pa;
    logic signed [PB_W-1:0]  r_pb, n_pb;
    logic signed [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0]        r_dvd, n_dvd;
    logic [DEN_W-1:0]        r_den, n_den;
    logic [DEN_W-1:0]        r_rem, n_rem;
    logic                    r_neg, n_neg;
    logic signed [RES_W-1:0] r_res, n_res;

    // Output register.
    t_status                 r_ostatus, n_ostatus;
    logic signed [OUT_W-1:0] r_omv, n_omv;
    logic [FILL_W-1:0]       r_ofill, n_ofill;

    logic [ADC_BITS-1:0]      w_adc_lo;
    logic [ADC_BITS-1:0]      w_adc_hi;
    logic signed [ADIFF_W-1:0] w_adiff;
    logic signed [ADIFF_W-1:0] w_adiff_abs;
    logic signed [ADIFF_W-1:0] w_cdiff;
    logic signed [VD_W-1:0]   w_vdiff;
    logic signed [PA_W-1:0]   w_pa;
    logic signed [PB_W-1:0]   w_pb;
    logic [DEN_W:0]           w_shift;
    logic                     w_ge;
    logic [DEN_W:0]           w_sub;
    logic signed [RES_W-1:0]  w_qmag;
    logic signed [RES_W-1:0]  w_vlo;
    logic signed [RES_W-1:0]  w_vhi;
    logic signed [RES_W-1:0]  w_vmin;
    logic signed [RES_W-1:0]  w_vmax;
    logic                     w_oob;
    logic signed [OUT_W-1:0]  w_sat;
    logic                     w_out_free;

    // Span terms of the linear map.
    assign w_adc_lo    = i_cfg.adc_low[ADC_BITS-1:0];
    assign w_adc_hi    = i_cfg.adc_high[ADC_BITS-1:0];
    assign w_adiff     = $signed({1'b0, w_adc_hi}) - $signed({1'b0, w_adc_lo});
    assign w_adiff_abs = w_adiff[ADIFF_W-1] ? -w_adiff : w_adiff;
    assign w_vdiff     = VD_W'(i_cfg.volt_high_mv) - VD_W'(i_cfg.volt_low_mv);
    assign w_cdiff     = $signed({1'b0, r_code}) - $signed({1'b0, w_adc_lo});

    // The two products of the numerator.
    assign w_pa = PA_W'(i_cfg.volt_low_mv) * PA_W'(w_adiff);
    assign w_pb = PB_W'(w_cdiff) * PB_W'(w_vdiff);

    // One restoring division step.
    assign w_shift = {r_rem, r_dvd[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    assign w_qmag = $signed(RES_W'(r_dvd));

    // Bounds check and saturation of the signed quotient.
    assign w_vlo  = RES_W'(i_cfg.volt_low_mv);
    assign w_vhi  = RES_W'(i_cfg.volt_high_mv);
    assign w_vmin = (w_vlo < w_vhi) ? w_vlo : w_vhi;
    assign w_vmax = (w_vlo < w_vhi) ? w_vhi : w_vlo;
    assign w_oob  = (r_res < w_vmin) || (r_res > w_vmax);
    always_comb begin
        if (r_res > RES_W'(OUT_MAX)) begin
            w_sat = OUT_MAX;
        end else if (r_res < RES_W'(OUT_MIN)) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = r_res[OUT_W-1:0];
        end
    end

    assign w_out_free  = !r_ovalid || i_out_ready;
    assign o_job_ready = (r_state == B_IDLE);

    // Next-state logic.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_code    = r_code;
        n_fill    = r_fill;
        n_kind    = r_kind;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_num     = r_num;
        n_dvd     = r_dvd;
        n_den     = r_den;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_res     = r_res;
        n_ostatus = r_ostatus;
        n_omv     = r_omv;
        n_ofill   = r_ofill;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_code = i_job_code;
                    n_fill = i_job_fill;
                    if (i_job_short) begin
                        n_kind  = ST_SHORT;
                        n_res   = '0;
                        n_state = B_FIN;
                    end else if ((w_adiff == '0) || (w_vdiff == '0)) begin
                        n_kind  = ST_ERR;
                        n_res   = '0;
                        n_state = B_FIN;
                    end else begin
                        n_kind  = ST_OK;
                        n_state = B_MUL;
                    end
                end
            end
            B_MUL: begin
                n_pa    = w_pa;
                n_pb    = w_pb;
                n_state = B_SUM;
            end
            B_SUM: begin
                n_num   = NUM_W'(r_pa) + NUM_W'(r_pb);
                n_state = B_ABS;
            end
            B_ABS: begin
                n_dvd   = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
                n_neg   = r_num[NUM_W-1] ^ w_adiff[ADIFF_W-1];
                n_den   = w_adiff_abs[DEN_W-1:0];
                n_rem   = '0;
                n_cnt   = CNT_W'(NUM_W);
                n_state = B_DIV;
            end
            B_DIV: begin
                n_rem = w_ge ? w_sub[DEN_W-1:0] : w_shift[DEN_W-1:0];
                n_dvd = {r_dvd[NUM_W-2:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = B_SGN;
                end
            end
            B_SGN: begin
                n_res   = r_neg ? -w_qmag : w_qmag;
                n_state = B_FIN;
            end
            B_FIN: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = (r_kind != ST_OK) ? r_kind : (w_oob ? ST_ERR : ST_OK);
                    n_omv     = w_sat;
                    n_ofill   = r_fill;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and output registers.
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_fill    <= n_fill;
        r_kind    <= n_kind;
        r_pa      <= n_pa;
        r_pb      <= n_pb;
        r_num     <= n_num;
        r_dvd     <= n_dvd;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_res     <= n_res;
        r_ostatus <= n_ostatus;
        r_omv     <= n_omv;
        r_ofill   <= n_ofill;
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_voltage_mv = r_omv;
    assign o_fill       = r_ofill;

endmodule

`default_nettype wire

/* sv/window_peak_voltmeter.sv */
// ============================================================================
// Window peak voltmeter
// Every sample request returns one reading request. The last window_length
// samples are kept in a ring memory; once the window is full the reading is
// the window midpoint (max+min)/2, or in amplitude mode (max-mid)*0.7071,
// mapped linearly from [adc_low, adc_high] onto [volt_low_mv, volt_high_mv]
// in millivolts, truncated toward zero and saturated to 24 bits. Status 1
// means the window is not yet full (reading 0); status 2 means a zero span
// (reading 0) or a result outside the voltage bounds (saturated reading).
// Once the window is full and holds two or more samples, the front end scans
// the ring through its single read port, one entry per cycle, and takes no
// new sample until the job is queued; amplitude mode adds a multiply and a
// correction state; a sample that leaves the window short skips the scan.
// The mapper's restoring divider produces one quotient bit per cycle over
// ADC_BITS + 24 bits; no new job is taken until the reading is registered.
// A two-entry queue between them lets the sustained rate follow the slower of
// the two. The ring needs no clearing after reset. Configuration is to be
// written only while no reading is outstanding; nothing enforces this.
// ============================================================================
`default_nettype none

module window_peak_voltmeter import wpv_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    wpv_in_if.sink                 i_smp,
    wpv_out_if.source              o_res
);

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int JOB_W  = 1 + FILL_W + ADC_BITS;

    t_cfg r_cfg;

    logic                w_job_valid;
    logic                w_job_ready;
    logic                w_job_short;
    logic [FILL_W-1:0]   w_job_fill;
    logic [ADC_BITS-1:0] w_job_code;
    logic                w_q_valid;
    logic                w_q_ready;
    logic [JOB_W-1:0]    w_q_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adc_low       <= ADC_MAX_BITS'(ADC_LOW_RST[ADC_BITS-1:0]);
            r_cfg.adc_high      <= ADC_MAX_BITS'(ADC_HIGH_RST[ADC_BITS-1:0]);
            r_cfg.volt_low_mv   <= VOLT_LOW_RST;
            r_cfg.volt_high_mv  <= VOLT_HIGH_RST;
            r_cfg.window_length <= WLEN_RST;
            r_cfg.rms_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ADC_LOW:   r_cfg.adc_low <= ADC_MAX_BITS'(i_cfg_wdata[ADC_BITS-1:0]);
                REG_ADC_HIGH:  r_cfg.adc_high <= ADC_MAX_BITS'(i_cfg_wdata[ADC_BITS-1:0]);
                REG_VOLT_LOW:  r_cfg.volt_low_mv <= $signed(i_cfg_wdata[VOLT_W-1:0]);
                REG_VOLT_HIGH: r_cfg.volt_high_mv <= $signed(i_cfg_wdata[VOLT_W-1:0]);
                REG_WLEN:      r_cfg.window_length <= i_cfg_wdata[WLEN_W-1:0];
                REG_RMS_MODE:  r_cfg.rms_mode <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Sample storage, window scan and code forming.
    wpv_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADC_BITS     (ADC_BITS),
        .FILL_W       (FILL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_smp_valid (i_smp.valid),
        .o_smp_ready (i_smp.ready),
        .i_sample    (i_smp.sample),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job_short (w_job_short),
        .o_job_fill  (w_job_fill),
        .o_job_code  (w_job_code)
    );

    // Queue between the front end and the mapper.
    wpv_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (JOB_Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_job_valid),
        .o_in_ready  (w_job_ready),
        .i_in_data   ({w_job_short, w_job_fill, w_job_code}),
        .o_out_valid (w_q_valid),
        .i_out_ready (w_q_ready),
        .o_out_data  (w_q_data)
    );

    // Linear map, bounds check and output register.
    wpv_back #(
        .ADC_BITS (ADC_BITS),
        .FILL_W   (FILL_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_valid  (w_q_valid),
        .o_job_ready  (w_q_ready),
        .i_job_short  (w_q_data[JOB_W-1]),
        .i_job_fill   (w_q_data[ADC_BITS +: FILL_W]),
        .i_job_code   (w_q_data[ADC_BITS-1:0]),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_status     (o_res.status),
        .o_voltage_mv (o_res.voltage_mv),
        .o_fill       (o_res.fill)
    );

endmodule

`default_nettype wire
